// File: design/twrtc_pkg.sv
// Shared types and constants for the three-wire RTC serial master.
// Used by twrtc_engine and three_wire_rtc_serial_master; depends on nothing.
package twrtc_pkg;

    // Operation codes carried by each input beat.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes and port widths.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETUP_TICKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_TICKS   = 1'b1;

    localparam logic [9:0] SETUP_TICKS_RESET = 10'd100;
    localparam logic [3:0] BIT_TICKS_RESET   = 4'd1;

    // Bus pin levels: enable, clock, data drive and driven data level.
    typedef struct packed {
        logic ce;
        logic sclk;
        logic drive;
        logic out;
    } t_pins;

    // One result beat.
    typedef struct packed {
        logic       ce;
        logic       sclk;
        logic       io_drive;
        logic       io_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       rejected;
    } t_result;

endpackage

// File: design/three_wire_rtc_serial_master.sv
// Top level of the three-wire RTC serial master: configuration registers,
// input handshake and the registered result stage. Depends on twrtc_pkg and twrtc_engine.
// The result of an accepted input beat is registered and presented in the next cycle.
// One beat per cycle unless the result stage stalls; each beat steps the sequencer once.
// Reset (synchronous, active low): idle, pins all high with data driven, no result held,
// setup_ticks = 100 and bit_ticks = 1.
module three_wire_rtc_serial_master (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [twrtc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [twrtc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_opcode,
    input  logic [7:0]                          i_address,
    input  logic [7:0]                          i_write_data,
    input  logic                                i_io_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_ce,
    output logic                                o_sclk,
    output logic                                o_io_drive,
    output logic                                o_io_out,
    output logic                                o_busy_res,
    output logic                                o_done_res,
    output logic [7:0]                          o_read_data,
    output logic                                o_rejected
);
    import twrtc_pkg::*;

    logic [9:0] r_setup_ticks;
    logic [3:0] r_bit_ticks;
    logic       r_out_valid;
    t_result    r_result;
    t_result    n_result;
    logic       in_accept;

    // A new beat is taken whenever the result register is empty or being
    // emptied in the same cycle, so the bus timing advances one tick per accepted beat.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept = i_in_valid && o_in_ready;

    // Configuration writes land immediately; the sequencer picks up a new
    // length the next time it enters a phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup_ticks <= SETUP_TICKS_RESET;
            r_bit_ticks <= BIT_TICKS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SETUP_TICKS: r_setup_ticks <= i_cfg_data[9:0];
                CFG_BIT_TICKS:   r_bit_ticks <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // The sequencer computes this tick's pin levels and status from its
    // state and the beat, and steps its state only on an accepted beat.
    twrtc_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_accept),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_io_in      (i_io_in),
        .i_setup_ticks(r_setup_ticks),
        .i_bit_ticks  (r_bit_ticks),
        .o_result     (n_result)
    );

    // Result register: the valid flag is control state, the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ce = r_result.ce;
    assign o_sclk = r_result.sclk;
    assign o_io_drive = r_result.io_drive;
    assign o_io_out = r_result.io_out;
    assign o_busy_res = r_result.busy_res;
    assign o_done_res = r_result.done_res;
    assign o_read_data = r_result.read_data;
    assign o_rejected = r_result.rejected;

    // The closing tick of a transaction is always reported as busy.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> o_busy_res)
        else $error("done without busy");

    // A released data pin never shows a driven level.
    a_released_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_io_drive) |-> !o_io_out)
        else $error("io_out high while released");

    // Read data appears only on the closing tick.
    a_rdata_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |-> (o_read_data == 8'd0))
        else $error("read_data outside done");

    // Every accepted beat leaves a result waiting in the next cycle.
    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted beat produced no result");

endmodule

// File: design/twrtc_engine.sv
// Transaction sequencer of the three-wire RTC master: phase state, hold counter and shifters.
// Depends on twrtc_pkg for the pin and result types and the operation codes.
module twrtc_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [1:0]       i_opcode,
    input  logic [7:0]       i_address,
    input  logic [7:0]       i_write_data,
    input  logic             i_io_in,
    input  logic [9:0]       i_setup_ticks,
    input  logic [3:0]       i_bit_ticks,
    output twrtc_pkg::t_result o_result
);
    import twrtc_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_CE_DOWN,
        PH_CLK_DOWN,
        PH_CE_UP,
        PH_LEAD,
        PH_CLK_LO,
        PH_DATA,
        PH_CLK_HI,
        PH_CLOSE_A,
        PH_CLOSE_B
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [9:0]  hold;
        logic [3:0]  bit_idx;
        logic [15:0] send;
        logic [7:0]  recv;
        logic        is_read;
        t_pins       pins;
    } t_state;

    localparam logic [3:0] LAST_ADDR_BIT = 4'd7;
    localparam logic [3:0] FIRST_DATA_BIT = 4'd8;
    localparam logic [3:0] LAST_DATA_BIT = 4'd15;

    localparam t_state STATE_RESET = '{
        phase:   PH_IDLE,
        hold:    10'd0,
        bit_idx: 4'd0,
        send:    16'd0,
        recv:    8'd0,
        is_read: 1'b0,
        pins:    4'hF
    };

    t_state r_state;
    t_state n_state;

    // Enter a phase: load its hold length and set the pins it changes.
    function automatic t_state f_enter(t_state s, t_phase p, logic [9:0] setup,
                                       logic [3:0] bitt);
        t_state     r;
        logic [9:0] len;
        r = s;
        len = (p == PH_CE_DOWN || p == PH_CLK_DOWN) ? setup : {6'd0, bitt};
        r.phase = p;
        r.hold = (len == 10'd0) ? 10'd1 : len;
        unique case (p)
            PH_CE_DOWN:  r.pins.ce = 1'b0;
            PH_CLK_DOWN: r.pins.sclk = 1'b0;
            PH_CE_UP:    r.pins.ce = 1'b1;
            PH_LEAD:     r.pins.drive = !s.bit_idx[3] || !s.is_read;
            PH_CLK_LO:   r.pins.sclk = 1'b0;
            PH_DATA: begin
                if (r.pins.drive) begin
                    r.pins.out = r.send[0];
                    r.send = {1'b0, r.send[15:1]};
                end
            end
            PH_CLK_HI:   r.pins.sclk = 1'b1;
            PH_CLOSE_A:  r.pins.ce = 1'b0;
            PH_CLOSE_B: begin
                if (r.is_read) begin
                    r.pins.ce = 1'b0;
                end else begin
                    r.pins.sclk = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always_comb begin
        t_state  s;
        t_result res;
        logic    start;
        s = r_state;
        res = '0;
        start = (i_opcode == OP_WRITE) || (i_opcode == OP_READ);

        if (s.phase == PH_IDLE) begin
            if (start) begin
                s.send = {i_write_data, i_address};
                s.is_read = (i_opcode == OP_READ);
                s.bit_idx = 4'd0;
                s.recv = 8'd0;
                s = f_enter(s, PH_CE_DOWN, i_setup_ticks, i_bit_ticks);
            end
        end else if (start) begin
            res.rejected = 1'b1;
        end

        res.ce = s.pins.ce;
        res.sclk = s.pins.sclk;
        res.io_drive = s.pins.drive;
        res.io_out = s.pins.drive & s.pins.out;

        if (s.phase != PH_IDLE) begin
            res.busy_res = 1'b1;
            if (s.hold > 10'd1) begin
                s.hold = s.hold - 10'd1;
            end else begin
                unique case (s.phase)
                    PH_CE_DOWN:  s = f_enter(s, PH_CLK_DOWN, i_setup_ticks, i_bit_ticks);
                    PH_CLK_DOWN: s = f_enter(s, PH_CE_UP, i_setup_ticks, i_bit_ticks);
                    PH_CE_UP:    s = f_enter(s, PH_LEAD, i_setup_ticks, i_bit_ticks);
                    PH_LEAD:     s = f_enter(s, PH_CLK_LO, i_setup_ticks, i_bit_ticks);
                    PH_CLK_LO: begin
                        // Read bits are sampled at the end of each clock-low phase.
                        if (s.is_read && s.bit_idx[3]) begin
                            s.recv = {i_io_in, s.recv[7:1]};
                        end
                        s = f_enter(s, PH_DATA, i_setup_ticks, i_bit_ticks);
                    end
                    PH_DATA:     s = f_enter(s, PH_CLK_HI, i_setup_ticks, i_bit_ticks);
                    PH_CLK_HI: begin
                        if (s.bit_idx == LAST_DATA_BIT) begin
                            s.bit_idx = 4'd0;
                            s = f_enter(s, PH_CLOSE_A, i_setup_ticks, i_bit_ticks);
                        end else if (s.bit_idx == LAST_ADDR_BIT) begin
                            s.bit_idx = FIRST_DATA_BIT;
                            s = f_enter(s, PH_LEAD, i_setup_ticks, i_bit_ticks);
                        end else begin
                            s.bit_idx = s.bit_idx + 4'd1;
                            s = f_enter(s, PH_CLK_LO, i_setup_ticks, i_bit_ticks);
                        end
                    end
                    PH_CLOSE_A:  s = f_enter(s, PH_CLOSE_B, i_setup_ticks, i_bit_ticks);
                    default: begin
                        res.done_res = 1'b1;
                        res.read_data = s.is_read ? s.recv : 8'd0;
                        s.phase = PH_IDLE;
                        s.hold = 10'd0;
                    end
                endcase
            end
        end

        n_state = s;
        o_result = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

endmodule

// File: tb/sv/three_wire_rtc_serial_master_tb.sv
// Self-checking testbench for the three-wire RTC serial master.
// Drives tick beats, predicts every pin-level result beat and compares them in order.
// Depends on twrtc_pkg and the three_wire_rtc_serial_master design.
`timescale 1ns / 100ps

module three_wire_rtc_serial_master_tb;
    import twrtc_pkg::*;

    // The package names the three defined operations. The fourth encoding is
    // an ordinary tick.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Cycle bounds for the run and for the deliberate receiver hold-off.
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 300;

    // Sequencer phases of the bus transaction, in the order they are entered.
    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_CE_DOWN, SEQ_CLK_DOWN, SEQ_CE_UP, SEQ_LEAD,
        SEQ_CLK_LO, SEQ_DATA, SEQ_CLK_HI, SEQ_CLOSE_A, SEQ_CLOSE_B
    } seq_phase_e;

    // One input beat: one bus tick with an optional start request.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] addr;
        logic [7:0] data;
        logic       io;
    } tick_beat_t;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data   = '0;
    logic                   i_in_valid   = 1'b0;
    logic                   o_in_ready;
    logic [1:0]             i_opcode     = OP_TICK;
    logic [7:0]             i_address    = '0;
    logic [7:0]             i_write_data = '0;
    logic                   i_io_in      = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready  = 1'b0;
    logic                   o_ce;
    logic                   o_sclk;
    logic                   o_io_drive;
    logic                   o_io_out;
    logic                   o_busy_res;
    logic                   o_done_res;
    logic [7:0]             o_read_data;
    logic                   o_rejected;

    three_wire_rtc_serial_master i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_io_in      (i_io_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_ce         (o_ce),
        .o_sclk       (o_sclk),
        .o_io_drive   (o_io_drive),
        .o_io_out     (o_io_out),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_read_data  (o_read_data),
        .o_rejected   (o_rejected)
    );

    // 20 ns clock, low half first.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Beats waiting to be offered, and the result beats the predictor says
    // must come back, oldest first.
    tick_beat_t ticks_to_send[$];
    t_result    pin_results_due[$];

    // Shadow copy of the configuration registers.
    logic [9:0] m_setup = SETUP_TICKS_RESET;
    logic [3:0] m_bits  = BIT_TICKS_RESET;

    // Shadow copy of the sequencer. The pins come out of reset all high with
    // the data pin driven.
    seq_phase_e m_phase   = SEQ_IDLE;
    logic [9:0] m_hold    = '0;
    logic [3:0] m_bit     = '0;
    logic [15:0] m_send   = '0;
    logic [7:0] m_recv    = '0;
    logic       m_is_read = 1'b0;
    t_pins      m_pins    = '1;

    // Bookkeeping for the summary and the verdict.
    int mismatch_count = 0;
    int beats_checked  = 0;
    int tx_done        = 0;
    int reads_done     = 0;
    int starts_refused = 0;
    int config_writes  = 0;
    int cycle_count    = 0;

    // Stimulus shaping. When quiet is set, neither side inserts idle cycles.
    // The generator tracks how many ticks of its current transaction remain,
    // so that each phase can end on a finished transaction.
    bit         quiet        = 1'b0;
    int         cur_len      = 0;
    int         gen_left     = 0;
    int         holds_asked  = 0;
    int         holds_done   = 0;
    int         hold_cycles  = 0;
    int         recv_gap     = 0;
    int         send_gap     = 0;
    tick_beat_t next_beat;

    // Ticks taken by one whole transaction, counting the start tick. A
    // register value of zero behaves as one.
    function automatic int tx_ticks(logic [9:0] s, logic [3:0] b);
        return 2 * ((s == 0) ? 1 : int'(s)) + 53 * ((b == 0) ? 1 : int'(b));
    endfunction

    // Idle cycles between beats: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Entering a phase loads its hold length and sets the pins that the
    // phase changes. The length is read from the registers at entry, so a
    // register write only affects phases entered after it.
    function automatic void seq_enter(seq_phase_e p);
        logic [9:0] len;
        len = (p == SEQ_CE_DOWN || p == SEQ_CLK_DOWN) ? m_setup : {6'd0, m_bits};
        m_phase = p;
        m_hold  = (len == 0) ? 10'd1 : len;
        case (p)
            SEQ_CE_DOWN:  m_pins.ce = 1'b0;
            SEQ_CLK_DOWN: m_pins.sclk = 1'b0;
            SEQ_CE_UP:    m_pins.ce = 1'b1;
            // The address byte is always driven. Before the second byte the
            // pin is released on a read.
            SEQ_LEAD:     m_pins.drive = (m_bit < 4'd8) ? 1'b1 : !m_is_read;
            SEQ_CLK_LO:   m_pins.sclk = 1'b0;
            SEQ_DATA: begin
                if (m_pins.drive) begin
                    m_pins.out = m_send[0];
                    m_send     = m_send >> 1;
                end
            end
            SEQ_CLK_HI:   m_pins.sclk = 1'b1;
            SEQ_CLOSE_A:  m_pins.ce = 1'b0;
            SEQ_CLOSE_B: begin
                if (m_is_read)
                    m_pins.ce = 1'b0;
                else
                    m_pins.sclk = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // Advances the shadow sequencer by one tick and returns the pin levels
    // and status that the block must report for that tick.
    function automatic t_result predict_tick(logic [1:0] op, logic [7:0] addr,
                                             logic [7:0] data, logic io);
        t_result r;
        logic    start;
        start = (op == OP_WRITE) || (op == OP_READ);
        r     = '0;

        if (m_phase == SEQ_IDLE) begin
            if (start) begin
                m_send    = {data, addr};
                m_is_read = (op == OP_READ);
                m_bit     = '0;
                m_recv    = '0;
                seq_enter(SEQ_CE_DOWN);
            end
        end else if (start) begin
            // A start while busy is dropped, even on the done tick.
            r.rejected = 1'b1;
            starts_refused++;
        end

        // The levels reported are those in force after a start has taken
        // effect, but before this tick's phase change.
        r.ce       = m_pins.ce;
        r.sclk     = m_pins.sclk;
        r.io_drive = m_pins.drive;
        r.io_out   = m_pins.drive & m_pins.out;

        if (m_phase != SEQ_IDLE) begin
            r.busy_res = 1'b1;
            if (m_hold > 1) begin
                m_hold--;
            end else begin
                case (m_phase)
                    SEQ_CE_DOWN:  seq_enter(SEQ_CLK_DOWN);
                    SEQ_CLK_DOWN: seq_enter(SEQ_CE_UP);
                    SEQ_CE_UP:    seq_enter(SEQ_LEAD);
                    SEQ_LEAD:     seq_enter(SEQ_CLK_LO);
                    SEQ_CLK_LO: begin
                        // Read bits are sampled at the end of clock low and
                        // enter from the top, so the first bit ends as bit 0.
                        if (m_is_read && m_bit >= 4'd8)
                            m_recv = {io, m_recv[7:1]};
                        seq_enter(SEQ_DATA);
                    end
                    SEQ_DATA:     seq_enter(SEQ_CLK_HI);
                    SEQ_CLK_HI: begin
                        if (m_bit == 4'd15) begin
                            m_bit = '0;
                            seq_enter(SEQ_CLOSE_A);
                        end else if (m_bit == 4'd7) begin
                            m_bit = 4'd8;
                            seq_enter(SEQ_LEAD);
                        end else begin
                            m_bit = m_bit + 4'd1;
                            seq_enter(SEQ_CLK_LO);
                        end
                    end
                    SEQ_CLOSE_A:  seq_enter(SEQ_CLOSE_B);
                    default: begin
                        r.done_res  = 1'b1;
                        r.read_data = m_is_read ? m_recv : 8'h00;
                        tx_done++;
                        if (m_is_read)
                            reads_done++;
                        m_phase = SEQ_IDLE;
                        m_hold  = '0;
                    end
                endcase
            end
        end
        return r;
    endfunction

    // Queues one tick beat and keeps the generator's transaction count in
    // step with it.
    task automatic offer(logic [1:0] op, logic [7:0] addr, logic [7:0] data, logic io);
        ticks_to_send.push_back('{op: op, addr: addr, data: data, io: io});
        if (gen_left > 0)
            gen_left--;
        else if (op == OP_WRITE || op == OP_READ)
            gen_left = cur_len - 1;
    endtask

    // Random byte and random pin level for stimulus fields.
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Random traffic for one register setting. Most beats form complete
    // transactions with random content. Inside a transaction, a few beats
    // are stray starts or the spare opcode. The last transaction is always
    // run to its end, so the block is idle afterwards.
    task automatic run_random(int budget);
        int         n;
        int         r;
        logic [1:0] op;
        n = 0;
        while (n < budget || gen_left > 0) begin
            r = $urandom_range(0, 99);
            if (gen_left == 0) begin
                if (r < 25)
                    op = $urandom_range(0, 1) ? OP_TICK : OP_SPARE;
                else
                    op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
            end else if (r < 4) begin
                op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
            end else if (r < 10) begin
                op = OP_SPARE;
            end else begin
                op = OP_TICK;
            end
            offer(op, rand_byte(), rand_byte(), rand_bit());
            n++;
        end
    endtask

    // Sender pause: wait until every queued beat has gone in and every
    // result has come back, then allow for the registered result stage.
    task automatic settle();
        while (ticks_to_send.size() != 0 || pin_results_due.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SETUP_TICKS)
            m_setup = val;
        else
            m_bits = val[3:0];
        cur_len = tx_ticks(m_setup, m_bits);
        config_writes++;
    endtask

    // Writes both registers. The upper bits of the bit_ticks write are
    // random, because only its low four bits count.
    task automatic set_timing(logic [9:0] s, logic [3:0] b);
        logic [CFG_DATA_W-1:0] v;
        v      = CFG_DATA_W'($urandom);
        v[3:0] = b;
        write_cfg(CFG_SETUP_TICKS, s);
        write_cfg(CFG_BIT_TICKS, v);
    endtask

    // Driver. On a handshake, the beat is fed to the predictor. A new beat,
    // or a gap cycle, is then chosen only once the current beat is gone.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready)
                pin_results_due.push_back(
                    predict_tick(i_opcode, i_address, i_write_data, i_io_in));
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (ticks_to_send.size() > 0) begin
                    next_beat = ticks_to_send.pop_front();
                    i_opcode     <= next_beat.op;
                    i_address    <= next_beat.addr;
                    i_write_data <= next_beat.data;
                    i_io_in      <= next_beat.io;
                    i_in_valid   <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready. A requested hold-off keeps ready low until a countdown from
    // LONG_HOLD runs out, so the result stage fills and the input side must stall.
    // Outside a hold-off, ready drops now and then for a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_ready <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done++;
            hold_cycles = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0)
                recv_gap = pick_gap();
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Monitor. Each result beat must match the oldest prediction, field by
    // field.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pin_results_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with none expected, got ce=%0b sclk=%0b busy=%0b",
                         $time, o_ce, o_sclk, o_busy_res);
            end else begin
                want = pin_results_due.pop_front();
                check_field("ce", int'(want.ce), int'(o_ce));
                check_field("sclk", int'(want.sclk), int'(o_sclk));
                check_field("io_drive", int'(want.io_drive), int'(o_io_drive));
                check_field("io_out", int'(want.io_out), int'(o_io_out));
                check_field("busy_res", int'(want.busy_res), int'(o_busy_res));
                check_field("done_res", int'(want.done_res), int'(o_done_res));
                check_field("read_data", int'(want.read_data), int'(o_read_data));
                check_field("rejected", int'(want.rejected), int'(o_rejected));
                beats_checked++;
            end
        end
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("three_wire_rtc_serial_master: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cur_len = tx_ticks(m_setup, m_bits);

        // Directed part, at the reset timing. A write of 0xA5 to command
        // 0x80 runs with a read start and a spare opcode while busy. Another
        // start then lands on the done tick and must be refused. It is
        // followed by a read that samples all ones.
        offer(OP_WRITE, 8'h80, 8'hA5, 1'b0);
        offer(OP_READ, 8'h81, 8'h00, 1'b1);
        offer(OP_SPARE, 8'hFF, 8'hFF, 1'b1);
        while (gen_left > 1)
            offer(OP_TICK, rand_byte(), rand_byte(), rand_bit());
        offer(OP_WRITE, 8'h00, 8'hFF, 1'b0);
        offer(OP_READ, 8'hFF, 8'h00, 1'b1);
        while (gen_left > 0)
            offer(OP_TICK, 8'h00, 8'h00, 1'b1);
        // Idle ticks must show the pins where the read left them.
        offer(OP_TICK, 8'hFF, 8'hFF, 1'b0);
        offer(OP_SPARE, 8'h00, 8'h00, 1'b1);
        settle();

        // Zero in both registers must behave as one tick. A read samples an
        // alternating pattern, and a write sends all ones.
        set_timing(10'd0, 4'd0);
        offer(OP_READ, 8'h00, 8'hFF, 1'b1);
        while (gen_left > 0)
            offer((gen_left % 2) ? OP_TICK : OP_SPARE, 8'h55, 8'hAA, 1'(gen_left % 2));
        offer(OP_WRITE, 8'hFF, 8'hFF, 1'b1);
        while (gen_left > 0)
            offer(OP_TICK, 8'h00, 8'h00, 1'b0);
        settle();

        // Shortest legal timing, with no idle cycles on either side.
        set_timing(10'd1, 4'd1);
        quiet = 1'b1;
        run_random(60);
        settle();
        quiet = 1'b0;

        // The receiver holds off for a long stretch while beats keep coming.
        set_timing(10'd4, 4'd2);
        run_random(80);
        holds_asked++;
        settle();

        // The sender pauses mid-setting until all results are back.
        set_timing(10'd9, 4'd1);
        run_random(40);
        settle();
        run_random(40);
        settle();

        set_timing(10'd2, 4'd3);
        run_random(40);
        settle();

        set_timing(10'd7, 4'd1);
        run_random(40);
        settle();

        // Any extra result beat during this tail is caught by the monitor.
        repeat (8) @(posedge i_clk);
        if (pin_results_due.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d result beats expected but never seen", $time,
                     pin_results_due.size());
        end

        $display("Checked %0d result beats: %0d transactions completed (%0d reads), %0d starts refused.",
                 beats_checked, tx_done, reads_done, starts_refused);
        $display("%0d register writes, setup_ticks 0 to 100 and bit_ticks 0 to 3.",
                 config_writes);
        if (mismatch_count == 0)
            $display("three_wire_rtc_serial_master: match");
        else
            $display("three_wire_rtc_serial_master: mismatch");
        $finish;
    end

endmodule
